### hdl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types, register codes and arithmetic helpers of the compensation core.
// ----------------------------------------------------------------------------
package bptc_pkg;

    typedef enum logic [1:0] {
        CFG_TEMP_TRIM = 2'd0,
        CFG_PRES_LOW  = 2'd1,
        CFG_PRES_MID  = 2'd2,
        CFG_PRES_HIGH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_trim;

    typedef struct packed {
        logic [17:0] temp_a;
        logic [16:0] temp_b;
        logic [20:0] pres_d;
    } t_front_item;

    localparam int ITEM_W = $bits(t_front_item);
    localparam int SIDE_W = 25;

    // low 64 bits of a 64-bit pattern times a 17-bit signed coefficient
    function automatic logic [63:0] f_mul64s(input logic [63:0] a, input logic [16:0] c);
        logic signed [49:0] lo;
        logic [31:0]        hi;
        logic [31:0]        cx;
        cx = {{15{c[16]}}, c};
        lo = $signed({1'b0, a[31:0]}) * $signed(c);
        hi = a[63:32] * cx;
        return {{14{lo[49]}}, lo} + {hi, 32'd0};
    endfunction

endpackage

### hdl/baro_temp_pressure_compensation_core.sv
// throughput: one item per cycle, set by the fully pipelined multiply stages
// and the 64-stage one-bit-per-stage divider; busy never rises in steady flow
// reset: synchronous active low, clears trims, queue and all stage valid bits
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Integer temperature and pressure compensation with packed trim registers.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core import bptc_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_done,
    output logic [23:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_pressure_valid
);

    logic [47:0] r_temp_trim;
    logic [63:0] r_pres_low;
    logic [63:0] r_pres_mid;
    logic [15:0] r_pres_high;
    t_trim       w_trim;

    logic        w_push;
    t_front_item w_front_item;
    logic        w_q_ready;
    logic        w_q_vld;
    logic [ITEM_W-1:0] w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_trim <= '0;
            r_pres_low  <= '0;
            r_pres_mid  <= '0;
            r_pres_high <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_TRIM: r_temp_trim <= i_cfg_data[47:0];
                CFG_PRES_LOW:  r_pres_low  <= i_cfg_data;
                CFG_PRES_MID:  r_pres_mid  <= i_cfg_data;
                CFG_PRES_HIGH: r_pres_high <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_trim.t1 = r_temp_trim[15:0];
        w_trim.t2 = r_temp_trim[31:16];
        w_trim.t3 = r_temp_trim[47:32];
        w_trim.p1 = r_pres_low[15:0];
        w_trim.p2 = r_pres_low[31:16];
        w_trim.p3 = r_pres_low[47:32];
        w_trim.p4 = r_pres_low[63:48];
        w_trim.p5 = r_pres_mid[15:0];
        w_trim.p6 = r_pres_mid[31:16];
        w_trim.p7 = r_pres_mid[47:32];
        w_trim.p8 = r_pres_mid[63:48];
        w_trim.p9 = r_pres_high;
    end

    bptc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_t1              (w_trim.t1),
        .i_q_ready         (w_q_ready),
        .o_busy            (o_busy),
        .o_push            (w_push),
        .o_item            (w_front_item)
    );

    bptc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_item),
        .i_pop   (w_q_vld),
        .o_ready (w_q_ready),
        .o_vld   (w_q_vld),
        .o_data  (w_q_data)
    );

    bptc_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_vld               (w_q_vld),
        .i_item              (t_front_item'(w_q_data)),
        .i_trim              (w_trim),
        .o_done              (o_done),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_q24_8    (o_pressure_q24_8),
        .o_pressure_valid    (o_pressure_valid)
    );

endmodule

### hdl/bptc_front.sv
// ----------------------------------------------------------------------------
// bptc_front
// Takes one reading pair, forms the trimmed temperature differences and the
// pressure offset, and hands the item to the queue.
// ----------------------------------------------------------------------------
module bptc_front import bptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic [15:0] i_t1,
    input  logic        i_q_ready,
    output logic        o_busy,
    output logic        o_push,
    output t_front_item o_item
);

    logic        r_vld;
    t_front_item r_item;
    t_front_item n_item;
    logic        w_accept;

    assign o_push   = r_vld & i_q_ready;
    assign o_busy   = r_vld & ~i_q_ready;
    assign w_accept = i_start & ~o_busy;
    assign o_item   = r_item;

    always_comb begin
        n_item.temp_a = {1'b0, i_raw_temperature[19:3]} - {1'b0, i_t1, 1'b0};
        n_item.temp_b = {1'b0, i_raw_temperature[19:4]} - {1'b0, i_t1};
        n_item.pres_d = 21'h100000 - {1'b0, i_raw_pressure};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    busy_holds_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> r_vld && $stable(r_item))
        else $error("front item lost while busy");

endmodule

### hdl/bptc_queue.sv
// ----------------------------------------------------------------------------
// bptc_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module bptc_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 56
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_vld,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [CW-1:0]    n_count;
    logic             w_pop;

    assign o_vld   = (r_count != '0);
    assign w_pop   = i_pop & o_vld;
    assign o_ready = (r_count != CW'(DEPTH)) | w_pop;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_ready)
        else $error("push into full queue");

    count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

### hdl/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero, with a sideband that travels alongside each item.
// ----------------------------------------------------------------------------
module bptc_div #(
    parameter int W      = 64,
    parameter int SIDE_W = 25
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [W-1:0]      i_num,
    input  logic [W-1:0]      i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [W-1:0]      o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [W+1];
    logic [W-1:0]      r_rem  [W+1];
    logic [W-1:0]      r_nq   [W+1];
    logic [W-1:0]      r_md   [W+1];
    logic              r_neg  [W+1];
    logic [SIDE_W-1:0] r_side [W+1];
    logic              r_out_vld;
    logic [W-1:0]      r_quo;
    logic [SIDE_W-1:0] r_out_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_nq[0]   <= i_num[W-1] ? ('0 - i_num) : i_num;
        r_md[0]   <= i_den[W-1] ? ('0 - i_den) : i_den;
        r_neg[0]  <= i_num[W-1] ^ i_den[W-1];
        r_side[0] <= i_side;
    end

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W-1:0] w_sh;
        logic         w_ge;
        assign w_sh = {r_rem[i][W-2:0], r_nq[i][W-1]};
        assign w_ge = (w_sh >= r_md[i]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[i+1]  <= w_ge ? (w_sh - r_md[i]) : w_sh;
            r_nq[i+1]   <= {r_nq[i][W-2:0], w_ge};
            r_md[i+1]   <= r_md[i];
            r_neg[i+1]  <= r_neg[i];
            r_side[i+1] <= r_side[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= r_neg[W] ? ('0 - r_nq[W]) : r_nq[W];
        r_out_side <= r_side[W];
    end

    assign o_vld  = r_out_vld;
    assign o_quo  = r_quo;
    assign o_side = r_out_side;

    fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> $past(i_vld, W + 2))
        else $error("divider output without matching input");

endmodule

### hdl/bptc_back.sv
// ----------------------------------------------------------------------------
// bptc_back
// Compensation pipeline: fine temperature, pressure divisor and dividend,
// pipelined divider, then the second-order pressure terms.
// ----------------------------------------------------------------------------
module bptc_back import bptc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_front_item i_item,
    input  t_trim       i_trim,
    output logic        o_done,
    output logic [23:0] o_temperature_centi,
    output logic [31:0] o_pressure_q24_8,
    output logic        o_pressure_valid
);

    logic [12:0] r_vld;

    // stage registers
    logic [31:0] r_s1_v1t;
    logic [19:0] r_s1_sb;
    logic [20:0] r_s1_pd;
    logic [31:0] r_s2_tfine;
    logic [20:0] r_s2_pd;
    logic [23:0] r_s3_tcent;
    logic [32:0] r_s3_v1;
    logic [20:0] r_s3_pd;
    logic [63:0] r_s4_sq;
    logic [32:0] r_s4_v1;
    logic [23:0] r_s4_tcent;
    logic [20:0] r_s4_pd;
    logic [63:0] r_s5_x6;
    logic [63:0] r_s5_t5;
    logic [63:0] r_s5_sq;
    logic [32:0] r_s5_v1;
    logic [23:0] r_s5_tcent;
    logic [20:0] r_s5_pd;
    logic [63:0] r_s6_v2;
    logic [63:0] r_s6_x3;
    logic [32:0] r_s6_v1;
    logic [23:0] r_s6_tcent;
    logic [20:0] r_s6_pd;
    logic [63:0] r_s7_v1b;
    logic [63:0] r_s7_u;
    logic [23:0] r_s7_tcent;
    logic [63:0] r_s8_y;
    logic [63:0] r_s8_u;
    logic [23:0] r_s8_tcent;
    logic [63:0] r_s9_den;
    logic [63:0] r_s9_num;
    logic [23:0] r_s9_tcent;
    logic        r_s9_ok;
    logic [31:0] r_d1_xl;
    logic [31:0] r_d1_xh;
    logic [63:0] r_d1_m0;
    logic [63:0] r_d1_q;
    logic [SIDE_W-1:0] r_d1_side;
    logic [63:0] r_d2_psq;
    logic [63:0] r_d2_q;
    logic [SIDE_W-1:0] r_d2_side;
    logic [39:0] r_d3_c1;
    logic [63:0] r_d3_q;
    logic [SIDE_W-1:0] r_d3_side;
    logic [39:0] r_d4_c1;
    logic [39:0] r_d4_c2;
    logic [39:0] r_d4_q;
    logic [SIDE_W-1:0] r_d4_side;
    logic        r_done;
    logic [23:0] r_tcent;
    logic [31:0] r_pres;
    logic        r_pres_ok;

    // next values
    logic signed [33:0] n_ma;
    logic signed [33:0] n_bb;
    logic signed [31:0] n_bb_sh;
    logic [31:0]        n_s1_v1t;
    logic signed [35:0] n_m3;
    logic [31:0]        n_v2t;
    logic [31:0]        n_tt;
    logic signed [65:0] n_sq_full;
    logic signed [48:0] n_mp5;
    logic signed [48:0] n_mp2;
    logic [63:0]        n_x3_sh;
    logic [63:0]        n_y_sh;
    logic [63:0]        n_ps;
    logic [31:0]        n_m1;
    logic [63:0]        n_x9;
    logic [63:0]        n_c1;
    logic [63:0]        n_x8;
    logic [63:0]        n_c2;
    logic [39:0]        n_sum;
    logic [31:0]        n_pres;

    logic              w_div_vld;
    logic [63:0]       w_div_quo;
    logic [SIDE_W-1:0] w_div_side;

    always_comb begin
        n_ma      = $signed(i_item.temp_a) * $signed(i_trim.t2);
        n_bb      = $signed(i_item.temp_b) * $signed(i_item.temp_b);
        n_s1_v1t  = $signed(n_ma[31:0]) >>> 11;
        n_bb_sh   = $signed(n_bb[31:0]) >>> 12;
        n_m3      = $signed(r_s1_sb) * $signed(i_trim.t3);
        n_v2t     = $signed(n_m3[31:0]) >>> 14;
        n_tt      = {r_s2_tfine[29:0], 2'b00} + r_s2_tfine + 32'd128;
        n_sq_full = $signed(r_s3_v1) * $signed(r_s3_v1);
        n_mp5     = $signed(r_s4_v1) * $signed(i_trim.p5);
        n_mp2     = $signed(r_s6_v1) * $signed(i_trim.p2);
        n_x3_sh   = $signed(r_s6_x3) >>> 8;
        n_y_sh    = $signed(r_s8_y) >>> 33;
        n_ps      = $signed(w_div_quo) >>> 13;
        n_m1      = r_d1_xh * r_d1_xl;
        n_x9      = f_mul64s(r_d2_psq, {i_trim.p9[15], i_trim.p9});
        n_c1      = $signed(n_x9) >>> 25;
        n_x8      = f_mul64s(r_d3_q, {i_trim.p8[15], i_trim.p8});
        n_c2      = $signed(n_x8) >>> 19;
        n_sum     = r_d4_q + r_d4_c1 + r_d4_c2;
        n_pres    = n_sum[39:8] + {{12{i_trim.p7[15]}}, i_trim.p7, 4'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[11:9], w_div_vld, r_vld[7:0], i_vld};
            r_done <= r_vld[12];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_v1t   <= n_s1_v1t;
        r_s1_sb    <= n_bb_sh[19:0];
        r_s1_pd    <= i_item.pres_d;

        r_s2_tfine <= r_s1_v1t + n_v2t;
        r_s2_pd    <= r_s1_pd;

        r_s3_tcent <= n_tt[31:8];
        r_s3_v1    <= {r_s2_tfine[31], r_s2_tfine} - 33'd128000;
        r_s3_pd    <= r_s2_pd;

        r_s4_sq    <= n_sq_full[63:0];
        r_s4_v1    <= r_s3_v1;
        r_s4_tcent <= r_s3_tcent;
        r_s4_pd    <= r_s3_pd;

        r_s5_x6    <= f_mul64s(r_s4_sq, {i_trim.p6[15], i_trim.p6});
        r_s5_t5    <= {{15{n_mp5[48]}}, n_mp5} << 17;
        r_s5_sq    <= r_s4_sq;
        r_s5_v1    <= r_s4_v1;
        r_s5_tcent <= r_s4_tcent;
        r_s5_pd    <= r_s4_pd;

        r_s6_v2    <= r_s5_x6 + r_s5_t5 + ({{48{i_trim.p4[15]}}, i_trim.p4} << 35);
        r_s6_x3    <= f_mul64s(r_s5_sq, {i_trim.p3[15], i_trim.p3});
        r_s6_v1    <= r_s5_v1;
        r_s6_tcent <= r_s5_tcent;
        r_s6_pd    <= r_s5_pd;

        r_s7_v1b   <= n_x3_sh + ({{15{n_mp2[48]}}, n_mp2} << 12);
        r_s7_u     <= ({43'd0, r_s6_pd} << 31) - r_s6_v2;
        r_s7_tcent <= r_s6_tcent;

        r_s8_y     <= f_mul64s(r_s7_v1b + 64'h0000_8000_0000_0000, {1'b0, i_trim.p1});
        r_s8_u     <= r_s7_u;
        r_s8_tcent <= r_s7_tcent;

        r_s9_den   <= n_y_sh;
        r_s9_ok    <= (n_y_sh != '0);
        r_s9_num   <= f_mul64s(r_s8_u, 17'd3125);
        r_s9_tcent <= r_s8_tcent;

        r_d1_xl    <= n_ps[31:0];
        r_d1_xh    <= n_ps[63:32];
        r_d1_m0    <= {32'd0, n_ps[31:0]} * {32'd0, n_ps[31:0]};
        r_d1_q     <= w_div_quo;
        r_d1_side  <= w_div_side;

        r_d2_psq   <= r_d1_m0 + {n_m1[30:0], 33'd0};
        r_d2_q     <= r_d1_q;
        r_d2_side  <= r_d1_side;

        r_d3_c1    <= n_c1[39:0];
        r_d3_q     <= r_d2_q;
        r_d3_side  <= r_d2_side;

        r_d4_c1    <= r_d3_c1;
        r_d4_c2    <= n_c2[39:0];
        r_d4_q     <= r_d3_q[39:0];
        r_d4_side  <= r_d3_side;

        r_tcent    <= r_d4_side[SIDE_W-1:1];
        r_pres_ok  <= r_d4_side[0];
        r_pres     <= r_d4_side[0] ? n_pres : '0;
    end

    bptc_div #(
        .W      (64),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[8]),
        .i_num   (r_s9_num),
        .i_den   (r_s9_den),
        .i_side  ({r_s9_tcent, r_s9_ok}),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    assign o_done              = r_done;
    assign o_temperature_centi = r_tcent;
    assign o_pressure_q24_8    = r_pres;
    assign o_pressure_valid    = r_pres_ok;

    zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_pressure_valid) |-> (o_pressure_q24_8 == '0))
        else $error("pressure not cleared for zero divisor");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the compensation core. Trims are loaded through the
// config channel while the core is idle, raw readings are sent as start items,
// and each done strobe is compared field by field against an in-bench model of
// the compensation or a table value. Directed rows cover reset trims, extremes
// and zero divisors; random phases cover the rest with random sender gaps.
// ----------------------------------------------------------------------------
module testbench;
    import bptc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 5000;
    localparam logic [63:0] TEMP_TYP = 64'h0000_FC18_6743_6B70;
    localparam logic [63:0] PLOW_TYP = 64'h0B27_0BD0_D643_8E7D;
    localparam logic [63:0] PMID_TYP = 64'hC6F8_3C8C_FFF9_008C;
    localparam logic [63:0] PHI_TYP  = 64'h0000_0000_0000_1770;

    typedef struct {
        logic [23:0] temp;
        logic [31:0] pres;
        logic        ok;
    } t_result;

    typedef struct {
        int          phase;
        logic [19:0] rt;
        logic [19:0] rp;
        bit          typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [19:0] i_raw_temperature = '0;
    logic [19:0] i_raw_pressure = '0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_cfg_ready;
    logic        o_done;
    logic [23:0] o_temperature_centi;
    logic [31:0] o_pressure_q24_8;
    logic        o_pressure_valid;

    logic [47:0] trim_temp = '0;
    logic [63:0] trim_plow = '0;
    logic [63:0] trim_pmid = '0;
    logic [15:0] trim_phigh = '0;

    t_result pending_q[$];
    t_result typed_want;
    bit      typed_armed = 0;
    int      items_taken = 0;
    int      writes_taken = 0;
    int      errors = 0;
    int      quiet = 0;

    baro_temp_pressure_compensation_core dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] asr32(input logic [31:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int n);
        return $signed(v) >>> n;
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic t_result compensate(input logic [19:0] rt, input logic [19:0] rp);
        logic [31:0] t1, t2, t3, a, b, m, v1t, v2t, tf, tc;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, x, num, mn, md, q, ps, c1, c2;
        t_result r;
        t1 = {16'd0, trim_temp[15:0]};
        t2 = {{16{trim_temp[31]}}, trim_temp[31:16]};
        t3 = {{16{trim_temp[47]}}, trim_temp[47:32]};
        a = ({12'd0, rt} >> 3) - (t1 << 1);
        m = a * t2;
        v1t = asr32(m, 11);
        b = ({12'd0, rt} >> 4) - t1;
        m = b * b;
        m = asr32(m, 12) * t3;
        v2t = asr32(m, 14);
        tf = v1t + v2t;
        tc = asr32(tf * 32'd5 + 32'd128, 8);
        p1 = {48'd0, trim_plow[15:0]};
        p2 = sext16(trim_plow[31:16]);
        p3 = sext16(trim_plow[47:32]);
        p4 = sext16(trim_plow[63:48]);
        p5 = sext16(trim_pmid[15:0]);
        p6 = sext16(trim_pmid[31:16]);
        p7 = sext16(trim_pmid[47:32]);
        p8 = sext16(trim_pmid[63:48]);
        p9 = sext16(trim_phigh);
        v1 = {{32{tf[31]}}, tf} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        r.temp = tc[23:0];
        r.pres = '0;
        r.ok = 1'b0;
        if (v1 != 0) begin
            x = 64'd1048576 - {44'd0, rp};
            num = ((x << 31) - v2) * 64'd3125;
            mn = num[63] ? -num : num;
            md = v1[63] ? -v1 : v1;
            q = mn / md;
            if (num[63] ^ v1[63]) begin
                q = -q;
            end
            ps = asr64(q, 13);
            c1 = asr64(p9 * ps * ps, 25);
            c2 = asr64(p8 * q, 19);
            x = asr64(q + c1 + c2, 8) + (p7 << 4);
            r.pres = x[31:0];
            r.ok = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result got, want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                writes_taken <= writes_taken + 1;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_TEMP_TRIM: trim_temp = i_cfg_data[47:0];
                    CFG_PRES_LOW:  trim_plow = i_cfg_data;
                    CFG_PRES_MID:  trim_pmid = i_cfg_data;
                    CFG_PRES_HIGH: trim_phigh = i_cfg_data[15:0];
                endcase
            end
            if (i_start && !o_busy) begin
                moved = 1'b1;
                items_taken <= items_taken + 1;
                pending_q.push_back(typed_armed ? typed_want
                                    : compensate(i_raw_temperature, i_raw_pressure));
            end
            if (o_done) begin
                moved = 1'b1;
                got.temp = o_temperature_centi;
                got.pres = o_pressure_q24_8;
                got.ok = o_pressure_valid;
                if (pending_q.size() == 0) begin
                    $error("result with no item outstanding");
                    errors++;
                end else begin
                    want = pending_q.pop_front();
                    if (got.temp !== want.temp) begin
                        $error("temperature_centi: expected %0d, got %0d",
                               $signed(want.temp), $signed(got.temp));
                        errors++;
                    end
                    if (got.pres !== want.pres) begin
                        $error("pressure_q24_8: expected %h, got %h", want.pres, got.pres);
                        errors++;
                    end
                    if (got.ok !== want.ok) begin
                        $error("pressure_valid: expected %b, got %b", want.ok, got.ok);
                        errors++;
                    end
                end
            end
            quiet <= moved ? 0 : quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [63:0] data);
        int target;
        i_start <= 1'b0;
        while (pending_q.size() != 0) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        target = writes_taken + 1;
        do @(negedge i_clk); while (writes_taken < target);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_trims(input logic [63:0] d0, d1, d2, d3);
        write_reg(CFG_TEMP_TRIM, d0);
        write_reg(CFG_PRES_LOW, d1);
        write_reg(CFG_PRES_MID, d2);
        write_reg(CFG_PRES_HIGH, d3);
    endtask

    task automatic send_item(input logic [19:0] rt, input logic [19:0] rp, input int gap);
        int target;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_raw_temperature <= rt;
        i_raw_pressure <= rp;
        target = items_taken + 1;
        do @(negedge i_clk); while (items_taken < target);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] jitter(input logic [63:0] base);
        return base ^ {4{12'd0, 4'($urandom_range(0, 15))}};
    endfunction

    t_row rows[] = '{
        '{0, 20'h00000, 20'h00000, 1, '{24'd0, 32'd0, 1'b0}},
        '{0, 20'hFFFFF, 20'hFFFFF, 1, '{24'd0, 32'd0, 1'b0}},
        '{0, 20'h00000, 20'hFFFFF, 1, '{24'd0, 32'd0, 1'b0}},
        '{0, 20'hFFFFF, 20'h00000, 1, '{24'd0, 32'd0, 1'b0}},
        '{1, 20'd519888, 20'd415148, 0, '{0, 0, 0}},
        '{1, 20'h00000, 20'h00000, 0, '{0, 0, 0}},
        '{1, 20'hFFFFF, 20'hFFFFF, 0, '{0, 0, 0}},
        '{1, 20'h80000, 20'h80000, 0, '{0, 0, 0}},
        '{1, 20'h55555, 20'hAAAAA, 0, '{0, 0, 0}},
        '{2, 20'h00000, 20'h00000, 0, '{0, 0, 0}},
        '{2, 20'hFFFFF, 20'hFFFFF, 0, '{0, 0, 0}},
        '{2, 20'hAAAAA, 20'h55555, 0, '{0, 0, 0}},
        '{3, 20'h00000, 20'hFFFFF, 0, '{0, 0, 0}},
        '{3, 20'hFFFFF, 20'h00000, 0, '{0, 0, 0}},
        '{3, 20'h7FFFF, 20'h7FFFF, 0, '{0, 0, 0}},
        '{4, 20'd519888, 20'd415148, 0, '{0, 0, 0}},
        '{4, 20'hFFFFF, 20'h00000, 0, '{0, 0, 0}},
        '{4, 20'h00000, 20'hFFFFF, 0, '{0, 0, 0}}
    };

    initial begin
        int phase;
        int gap_max;
        phase = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].phase != phase) begin
                phase = rows[k].phase;
                case (phase)
                    1: load_trims(TEMP_TYP, PLOW_TYP, PMID_TYP, PHI_TYP);
                    2: load_trims('1, '1, '1, '1);
                    3: load_trims({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
                    default: load_trims(TEMP_TYP, PLOW_TYP & ~64'hFFFF, PMID_TYP, PHI_TYP);
                endcase
            end
            typed_armed = rows[k].typed;
            typed_want = rows[k].want;
            send_item(rows[k].rt, rows[k].rp, $urandom_range(0, 3));
            typed_armed = 0;
        end

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: load_trims(rand64(), rand64(), rand64(), rand64());
                1: load_trims(jitter(TEMP_TYP), jitter(PLOW_TYP), jitter(PMID_TYP),
                              jitter(PHI_TYP));
                2: load_trims(TEMP_TYP, PLOW_TYP, PMID_TYP, PHI_TYP);
                default: load_trims(jitter(TEMP_TYP), rand64(), jitter(PMID_TYP), rand64());
            endcase
            gap_max = (ph % 2) ? 0 : 15;
            for (int n = 0; n < 66; n++) begin
                if (ph == 2 && n == 33) begin
                    i_start <= 1'b0;
                    while (pending_q.size() != 0) begin
                        @(negedge i_clk);
                    end
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_item(20'($urandom_range(0, 20'hFFFFF)),
                              20'($urandom_range(0, 20'hFFFFF)),
                              $urandom_range(0, gap_max));
                end else begin
                    send_item(20'($urandom_range(380000, 620000)),
                              20'($urandom_range(200000, 600000)),
                              $urandom_range(0, gap_max));
                end
            end
        end

        i_start <= 1'b0;
        while (pending_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
